### src/lab_statistics_color_transfer_unit_assert.svh
// Assertion macros shared by the colour transfer RTL.
`ifndef LAB_STATISTICS_COLOR_TRANSFER_UNIT_ASSERT_SVH
`define LAB_STATISTICS_COLOR_TRANSFER_UNIT_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define LSCT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lsct assertion failed");

// Whenever a holds, b must hold in the same cycle.
`define LSCT_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("lsct assertion failed");

`endif

### src/lsct_pkg.sv
// Constants, codes and controller/datapath interface types of the colour transfer unit.
package lsct_pkg;

	localparam int MAX_PIXELS_LOG2 = 22;
	localparam int FRAC_BITS = 16;
	localparam int NUM_CHAN = 3;

	localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
	localparam int SUM_W = MAX_PIXELS_LOG2 + 8;
	localparam int SQ_W = MAX_PIXELS_LOG2 + 16;
	localparam int MEAN_W = 8 + FRAC_BITS;
	localparam int E2_W = 16 + 2 * FRAC_BITS;
	localparam int DEV_W = 8 + FRAC_BITS;
	localparam int RATIO_W = FRAC_BITS + 16;
	localparam int DVD_W = SQ_W + 2 * FRAC_BITS;
	localparam int DEN_W = (CNT_W > DEV_W) ? CNT_W : DEV_W;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);
	localparam int SQ_STEPS = E2_W / 2;
	localparam int SQ_CNT_W = $clog2(SQ_STEPS + 1);
	localparam int PROD_W = RATIO_W + MEAN_W;
	localparam int LIM_W = (PROD_W > 63) ? PROD_W : 63;
	localparam int ACC_W = LIM_W + 1;

	localparam logic [1:0] LAST_CHAN = 2'(NUM_CHAN - 1);

	// Request kinds carried in the input tuser.
	localparam logic [1:0] OP_TARGET = 2'd0;
	localparam logic [1:0] OP_SOURCE = 2'd1;
	localparam logic [1:0] OP_TRANSFORM = 2'd2;

	// Result status codes carried in the output tuser.
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FLAT = 2'd1;
	localparam logic [1:0] STAT_NOT_READY = 2'd2;

	// Dividend selection of the shared divider.
	localparam logic [1:0] DIV_MEAN = 2'd0;
	localparam logic [1:0] DIV_E2 = 2'd1;
	localparam logic [1:0] DIV_RATIO = 2'd2;

	typedef struct packed {
		logic       acc_en;
		logic       acc_side;
		logic       xf_cap;
		logic       side;
		logic [1:0] chan;
		logic       div_start;
		logic [1:0] div_sel;
		logic       st_mean;
		logic       st_e2;
		logic       mul_sq;
		logic       sqrt_start;
		logic       st_dev;
		logic       st_ratio;
		logic       ratio_zero;
		logic       clr_flat;
		logic       set_ready;
		logic       xf_d;
		logic       xf_mul;
		logic       xf_res;
		logic       out_load;
	} lsct_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic dev_src_zero;
		logic stats_ready;
		logic out_free;
	} lsct_sts_t;

endpackage

### src/lab_statistics_color_transfer_unit.sv
// Top level of the Lab statistics colour transfer unit.
// The unit takes 8-bit Lab pixels in three passes, told apart by s_tuser: target pixels
// to accumulate, source pixels to accumulate, and source pixels to transform. The
// controller takes accumulate requests while it is idle. The request that carries tlast
// in the source pass starts the statistics computation: per channel the means, the
// deviations (variance as E[x^2] minus the squared mean) and the target-to-source
// deviation ratio, in fixed point. This is done by one shared divider that yields one
// quotient bit per cycle and a square root unit that yields one bit per cycle; no
// input request is taken while it runs. A transform request, once accepted, runs
// through three channels, each of difference, multiply and result steps, then the load
// of the output register, and no next request is taken before that load; a transform
// before the statistics are ready skips the channel steps and needs only the load. The
// load waits while the output register still holds a result that has not been taken. The
// output register lets accumulate requests and the work on the next transform proceed
// while a result still waits to be taken. Each transform gives one result: status 0
// normally, 1 when some source channel is flat (that channel then yields the target
// mean), and 2 with zero pixels when no statistics are ready yet. An accumulate request
// after the statistics are ready starts a new image.
module lab_statistics_color_transfer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // chan_l [7:0], chan_a [15:8], chan_b [23:16]
	input  logic [1:0]  s_tuser,  // op [1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_l [7:0], out_a [15:8], out_b [23:16]
	output logic [1:0]  m_tuser,  // status [1:0]
	output logic        m_tlast
);
	import lsct_pkg::*;

	// Commands from the controller and status back from the datapath.
	lsct_cmd_t cmd;
	lsct_sts_t sts;

	lsct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsct_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### src/lsct_ctrl.sv
// Controller state machine of the colour transfer unit.
module lsct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        s_tuser,
	input  logic              s_tlast,
	input  lsct_pkg::lsct_sts_t sts,
	output lsct_pkg::lsct_cmd_t cmd
);
	import lsct_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_XF_D   = 4'd1;
	localparam logic [3:0] ST_XF_M   = 4'd2;
	localparam logic [3:0] ST_XF_R   = 4'd3;
	localparam logic [3:0] ST_OUT    = 4'd4;
	localparam logic [3:0] ST_S_MEAN = 4'd5;
	localparam logic [3:0] ST_W_MEAN = 4'd6;
	localparam logic [3:0] ST_S_E2   = 4'd7;
	localparam logic [3:0] ST_W_E2   = 4'd8;
	localparam logic [3:0] ST_MSQ    = 4'd9;
	localparam logic [3:0] ST_S_SQRT = 4'd10;
	localparam logic [3:0] ST_W_SQRT = 4'd11;
	localparam logic [3:0] ST_S_RAT  = 4'd12;
	localparam logic [3:0] ST_W_RAT  = 4'd13;

	logic [3:0] state_q, state_d;
	logic       side_q, side_d;
	logic [1:0] chan_q, chan_d;

	always_comb begin
		cmd = '0;
		cmd.side = side_q;
		cmd.chan = chan_q;
		state_d = state_q;
		side_d = side_q;
		chan_d = chan_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				chan_d = 2'd0;
				side_d = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						OP_TARGET: begin
							cmd.acc_en = 1'b1;
							cmd.acc_side = 1'b0;
						end
						OP_SOURCE: begin
							cmd.acc_en = 1'b1;
							cmd.acc_side = 1'b1;
							if (s_tlast) begin
								cmd.clr_flat = 1'b1;
								state_d = ST_S_MEAN;
							end
						end
						OP_TRANSFORM: begin
							cmd.xf_cap = 1'b1;
							state_d = sts.stats_ready ? ST_XF_D : ST_OUT;
						end
						default: ;
					endcase
				end
			end
			ST_XF_D: begin
				cmd.xf_d = 1'b1;
				state_d = ST_XF_M;
			end
			ST_XF_M: begin
				cmd.xf_mul = 1'b1;
				state_d = ST_XF_R;
			end
			ST_XF_R: begin
				cmd.xf_res = 1'b1;
				if (chan_q == LAST_CHAN) begin
					state_d = ST_OUT;
				end else begin
					chan_d = chan_q + 2'd1;
					state_d = ST_XF_D;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_S_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_MEAN;
				state_d = ST_W_MEAN;
			end
			ST_W_MEAN: begin
				if (!sts.div_busy) begin
					cmd.st_mean = 1'b1;
					state_d = ST_S_E2;
				end
			end
			ST_S_E2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_E2;
				state_d = ST_W_E2;
			end
			ST_W_E2: begin
				if (!sts.div_busy) begin
					cmd.st_e2 = 1'b1;
					state_d = ST_MSQ;
				end
			end
			ST_MSQ: begin
				cmd.mul_sq = 1'b1;
				state_d = ST_S_SQRT;
			end
			ST_S_SQRT: begin
				cmd.sqrt_start = 1'b1;
				state_d = ST_W_SQRT;
			end
			ST_W_SQRT: begin
				if (!sts.sqrt_busy) begin
					cmd.st_dev = 1'b1;
					if (side_q) begin
						side_d = 1'b0;
						state_d = ST_S_MEAN;
					end else begin
						state_d = ST_S_RAT;
					end
				end
			end
			ST_S_RAT: begin
				if (sts.dev_src_zero) begin
					cmd.ratio_zero = 1'b1;
					if (chan_q == LAST_CHAN) begin
						cmd.set_ready = 1'b1;
						state_d = ST_IDLE;
					end else begin
						chan_d = chan_q + 2'd1;
						side_d = 1'b1;
						state_d = ST_S_MEAN;
					end
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DIV_RATIO;
					state_d = ST_W_RAT;
				end
			end
			ST_W_RAT: begin
				if (!sts.div_busy) begin
					cmd.st_ratio = 1'b1;
					if (chan_q == LAST_CHAN) begin
						cmd.set_ready = 1'b1;
						state_d = ST_IDLE;
					end else begin
						chan_d = chan_q + 2'd1;
						side_d = 1'b1;
						state_d = ST_S_MEAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q <= 1'b1;
			chan_q <= 2'd0;
		end else begin
			state_q <= state_d;
			side_q <= side_d;
			chan_q <= chan_d;
		end
	end

endmodule

### src/lsct_dp.sv
// Datapath of the colour transfer unit: accumulators, divider, square root, multiplier, output.
`include "lab_statistics_color_transfer_unit_assert.svh"
module lsct_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lsct_pkg::lsct_cmd_t cmd,
	output lsct_pkg::lsct_sts_t sts,
	input  logic [23:0]       s_tdata,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);
	import lsct_pkg::*;

	localparam logic [LIM_W-1:0] PROD_LIMIT = LIM_W'(1) << 62;
	localparam logic [E2_W-1:0] SQ_BIT0 = E2_W'(1) << (E2_W - 2);

	// Accumulated statistics, index 0 target, 1 source.
	logic [CNT_W-1:0]   cnt_q [2];
	logic [SUM_W-1:0]   sum_q [2][NUM_CHAN];
	logic [SQ_W-1:0]    sq_q [2][NUM_CHAN];
	logic [MEAN_W-1:0]  mean_q [2][NUM_CHAN];
	logic [RATIO_W-1:0] ratio_q [NUM_CHAN];
	logic [DEV_W-1:0]   dev_q [2];
	logic [E2_W-1:0]    e2_q;
	logic               ready_q, flat_q;

	// Shared divider.
	logic [DVD_W-1:0]     div_dvd_q, div_quo_q, dvd_in;
	logic [DEN_W-1:0]     div_den_q, div_rem_q, den_in;
	logic [DEN_W:0]       div_t;
	logic                 div_ge, div_busy_q, div_zero_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Square root unit.
	logic [E2_W-1:0]     sq_v_q, sq_res_q, sq_bit_q, sq_sum, var_in;
	logic                sq_busy_q;
	logic [SQ_CNT_W-1:0] sq_cnt_q;

	// Multiplier and transform.
	logic [RATIO_W-1:0] mul_a;
	logic [MEAN_W-1:0]  mul_b, xf_val, d_q;
	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic [7:0]         px_q [NUM_CHAN];
	logic [7:0]         res_q [NUM_CHAN];
	logic               last_q;
	logic [ACC_W-1:0]   base_x, prod_x, acc_x, shr_x;
	logic [7:0]         res_val;

	logic [SUM_W-1:0]   sum_sel;
	logic [SQ_W-1:0]    sq_sel;
	logic [CNT_W-1:0]   cnt_sel, acc_cnt;
	logic [MEAN_W-1:0]  mean_sel;

	assign sum_sel = sum_q[cmd.side][cmd.chan];
	assign sq_sel = sq_q[cmd.side][cmd.chan];
	assign cnt_sel = cnt_q[cmd.side];
	assign mean_sel = mean_q[cmd.side][cmd.chan];
	assign acc_cnt = ready_q ? '0 : cnt_q[cmd.acc_side];

	always_comb begin
		case (cmd.div_sel)
			DIV_MEAN: dvd_in = DVD_W'({sum_sel, {FRAC_BITS{1'b0}}});
			DIV_E2:   dvd_in = DVD_W'({sq_sel, {(2 * FRAC_BITS){1'b0}}});
			DIV_RATIO: dvd_in = DVD_W'({dev_q[0], {FRAC_BITS{1'b0}}});
			default:  dvd_in = '0;
		endcase
		den_in = (cmd.div_sel == DIV_RATIO) ? DEN_W'(dev_q[1]) : DEN_W'(cnt_sel);
	end

	assign div_t = {div_rem_q, div_dvd_q[DVD_W-1]};
	assign div_ge = div_t >= {1'b0, div_den_q};

	assign var_in = (PROD_W'(e2_q) > prod_q) ? E2_W'(PROD_W'(e2_q) - prod_q) : '0;
	assign sq_sum = sq_res_q + sq_bit_q;

	assign mul_a = cmd.mul_sq ? RATIO_W'(mean_sel) : ratio_q[cmd.chan];
	assign mul_b = cmd.mul_sq ? mean_sel : d_q;

	assign xf_val = {px_q[cmd.chan], {FRAC_BITS{1'b0}}};

	always_comb begin
		base_x = ACC_W'({mean_q[0][cmd.chan], {FRAC_BITS{1'b0}}});
		prod_x = ACC_W'(prod_q);
		acc_x = '0;
		res_val = 8'd0;
		if (LIM_W'(prod_q) > PROD_LIMIT) begin
			res_val = neg_q ? 8'd0 : 8'd255;
		end else if (neg_q && prod_x >= base_x) begin
			res_val = 8'd0;
		end else begin
			acc_x = neg_q ? base_x - prod_x : base_x + prod_x;
			res_val = (shr_x > ACC_W'(255)) ? 8'd255 : shr_x[7:0];
		end
	end
	assign shr_x = acc_x >> (2 * FRAC_BITS);

	// Accumulators and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				cnt_q[s] <= '0;
				dev_q[s] <= '0;
				for (int c = 0; c < NUM_CHAN; c++) begin
					sum_q[s][c] <= '0;
					sq_q[s][c] <= '0;
					mean_q[s][c] <= '0;
				end
			end
			for (int c = 0; c < NUM_CHAN; c++) ratio_q[c] <= '0;
			e2_q <= '0;
			ready_q <= 1'b0;
			flat_q <= 1'b0;
		end else begin
			if (cmd.acc_en) begin
				// A new image: the side being accumulated restarts from zero below.
				if (ready_q) begin
					ready_q <= 1'b0;
					for (int s = 0; s < 2; s++) begin
						if (s != int'(cmd.acc_side)) begin
							cnt_q[s] <= '0;
							for (int c = 0; c < NUM_CHAN; c++) begin
								sum_q[s][c] <= '0;
								sq_q[s][c] <= '0;
							end
						end
					end
				end
				if (!acc_cnt[CNT_W-1]) begin
					cnt_q[cmd.acc_side] <= acc_cnt + CNT_W'(1);
					for (int c = 0; c < NUM_CHAN; c++) begin
						sum_q[cmd.acc_side][c] <= (ready_q ? '0 : sum_q[cmd.acc_side][c])
							+ SUM_W'(s_tdata[8*c +: 8]);
						sq_q[cmd.acc_side][c] <= (ready_q ? '0 : sq_q[cmd.acc_side][c])
							+ SQ_W'(16'(s_tdata[8*c +: 8]) * 16'(s_tdata[8*c +: 8]));
					end
				end
			end
			if (cmd.clr_flat) flat_q <= 1'b0;
			if (cmd.st_mean) begin
				mean_q[cmd.side][cmd.chan] <= div_zero_q ? '0 : div_quo_q[MEAN_W-1:0];
			end
			if (cmd.st_e2) e2_q <= div_zero_q ? '0 : div_quo_q[E2_W-1:0];
			if (cmd.st_dev) dev_q[cmd.side] <= sq_res_q[DEV_W-1:0];
			if (cmd.ratio_zero) begin
				ratio_q[cmd.chan] <= '0;
				flat_q <= 1'b1;
			end
			if (cmd.st_ratio) begin
				ratio_q[cmd.chan] <= (|div_quo_q[DVD_W-1:RATIO_W]) ? '1 :
					div_quo_q[RATIO_W-1:0];
			end
			if (cmd.set_ready) ready_q <= 1'b1;
		end
	end

	// Restoring divider, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= DIV_CNT_W'(DVD_W);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			if (div_cnt_q == DIV_CNT_W'(1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_dvd_q <= dvd_in;
			div_den_q <= den_in;
			div_zero_q <= (den_in == '0);
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_busy_q) begin
			div_dvd_q <= div_dvd_q << 1;
			div_rem_q <= div_ge ? DEN_W'(div_t - {1'b0, div_den_q}) : div_t[DEN_W-1:0];
			div_quo_q <= {div_quo_q[DVD_W-2:0], div_ge};
		end
	end

	// Square root, one result bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_start) begin
			sq_busy_q <= 1'b1;
			sq_cnt_q <= SQ_CNT_W'(SQ_STEPS);
		end else if (sq_busy_q) begin
			sq_cnt_q <= sq_cnt_q - SQ_CNT_W'(1);
			if (sq_cnt_q == SQ_CNT_W'(1)) sq_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_v_q <= var_in;
			sq_res_q <= '0;
			sq_bit_q <= SQ_BIT0;
		end else if (sq_busy_q) begin
			if (sq_v_q >= sq_sum) begin
				sq_v_q <= sq_v_q - sq_sum;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
	end

	// Multiplier and per-channel transform steps.
	always_ff @(posedge clk) begin
		if (cmd.mul_sq || cmd.xf_mul) prod_q <= mul_a * mul_b;
		if (cmd.xf_cap) begin
			for (int c = 0; c < NUM_CHAN; c++) px_q[c] <= s_tdata[8*c +: 8];
			last_q <= s_tlast;
		end
		if (cmd.xf_d) begin
			neg_q <= xf_val < mean_q[1][cmd.chan];
			d_q <= (xf_val < mean_q[1][cmd.chan]) ? mean_q[1][cmd.chan] - xf_val :
				xf_val - mean_q[1][cmd.chan];
		end
		if (cmd.xf_res) res_q[cmd.chan] <= res_val;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= ready_q ? {res_q[2], res_q[1], res_q[0]} : '0;
			m_tuser <= ready_q ? (flat_q ? STAT_FLAT : STAT_OK) : STAT_NOT_READY;
			m_tlast <= last_q;
		end
	end

	assign sts.div_busy = div_busy_q;
	assign sts.sqrt_busy = sq_busy_q;
	assign sts.dev_src_zero = (dev_q[1] == '0);
	assign sts.stats_ready = ready_q;
	assign sts.out_free = !m_tvalid || m_tready;

	`LSCT_ASSERT_NEVER(a_div_restart, clk, arst_n, cmd.div_start && div_busy_q)
	`LSCT_ASSERT_NEVER(a_sqrt_restart, clk, arst_n, cmd.sqrt_start && sq_busy_q)
	`LSCT_ASSERT_IMP(a_out_free, clk, arst_n, cmd.out_load, !m_tvalid || m_tready)
	`LSCT_ASSERT_IMP(a_acc_quiet, clk, arst_n, cmd.acc_en, !div_busy_q && !sq_busy_q)

endmodule
